@@ rtl/core/rdc_pkg.sv @@
// Shared types, constants and the digit character function of the radix digit converter.
`default_nettype none
package rdc_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int RADIX_WIDTH    = 5;
    localparam int DIGIT_WIDTH    = 4;
    localparam int CHAR_WIDTH     = 7;
    localparam int STACK_SLOTS    = 32;
    localparam int STACK_AW       = $clog2(STACK_SLOTS);
    localparam int DEPTH_WIDTH    = STACK_AW + 1;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [RADIX_WIDTH-1:0] MIN_RADIX  = 5'd2;
    localparam logic [RADIX_WIDTH-1:0] MAX_RADIX  = 5'd16;
    localparam logic [DIGIT_WIDTH-1:0] DEC_DIGITS = 4'd10;
    localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0]  CHAR_A     = 7'd65;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_WIDTH-1:0] radix;
    } rdc_in_t;

    typedef struct packed {
        logic [DIGIT_WIDTH-1:0] digit;
        logic [CHAR_WIDTH-1:0]  digit_char;
        logic                   last;
        logic                   bad_radix;
    } rdc_out_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic                   done;
        logic [DIGIT_WIDTH-1:0] remainder;
    } rdc_div_stat_t;

    // digit stack access from the sequencer
    typedef struct packed {
        logic                   wr_en;
        logic [STACK_AW-1:0]    wr_addr;
        logic [DIGIT_WIDTH-1:0] wr_data;
        logic                   rd_en;
        logic [STACK_AW-1:0]    rd_addr;
    } rdc_stack_req_t;

    function automatic logic [CHAR_WIDTH-1:0] rdc_digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] ch;
        if (d < DEC_DIGITS)
        begin
            ch = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            ch = CHAR_A + {3'b000, d} - {3'b000, DEC_DIGITS};
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/radix_digit_converter_top.sv @@
// Radix digit converter top level: sequencer, output register and submodule wiring.
//
// Converts an unsigned value (its low VALUE_BITS bits, at most 32) into digits of a radix
// from 2 to 16, most significant first, one output word per digit with its ASCII character
// and a last flag; a zero value gives the single digit 0, a radix outside 2..16 gives one
// word with bad_radix set. Each digit comes from the bit-serial divider, and the push happens
// in the divider's done cycle; popping then goes through the registered stack read, a read
// state and then a load state per digit, the load waiting for a free output register. The
// block takes no new word until the last digit is in the output register; that word may
// still wait there while the next word is accepted.
`default_nettype none
module radix_digit_converter_top
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output      logic     req_ready,
    input  wire rdc_in_t  req_word,
    output      logic     rsp_valid,
    input  wire logic     rsp_ready,
    output      rdc_out_t rsp_word
);

    localparam int QW = (VALUE_BITS < VALUE_WIDTH) ? VALUE_BITS : VALUE_WIDTH;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_POP_RD = 3'd2;
    localparam logic [2:0] ST_POP_LD = 3'd3;
    localparam logic [2:0] ST_ERR    = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [DEPTH_WIDTH-1:0] depth_reg, depth_next;
    logic [RADIX_WIDTH-1:0] radix_reg, radix_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rdc_out_t               rsp_word_reg, rsp_word_next;

    logic                   accept;
    logic                   bad;
    logic                   slot_free;
    logic                   div_start;
    logic [QW-1:0]          div_dividend;
    logic [QW-1:0]          quotient;
    rdc_div_stat_t          div_stat;
    rdc_stack_req_t         stack_req;
    logic [DIGIT_WIDTH-1:0] stack_rd_data;
    logic [DEPTH_WIDTH-1:0] depth_dec;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign bad       = (req_word.radix < MIN_RADIX) || (req_word.radix > MAX_RADIX);
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign depth_dec = depth_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        radix_next     = radix_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_word_next  = rsp_word_reg;
        div_start      = 1'b0;
        div_dividend   = quotient;
        stack_req      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                div_dividend = req_word.value[QW-1:0];
                if (accept)
                begin
                    if (bad)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        depth_next = '0;
                        radix_next = req_word.radix;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (depth_reg < DEPTH_WIDTH'(STACK_SLOTS))
                    begin
                        stack_req.wr_en   = 1'b1;
                        stack_req.wr_addr = depth_reg[STACK_AW-1:0];
                        stack_req.wr_data = div_stat.remainder;
                        depth_next        = depth_reg + 1'b1;
                    end
                    if (quotient != '0)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD:
            begin
                stack_req.rd_en   = 1'b1;
                stack_req.rd_addr = depth_dec[STACK_AW-1:0];
                depth_next        = depth_dec;
                state_next        = ST_POP_LD;
            end
            ST_POP_LD:
            begin
                if (slot_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_word_next.digit      = stack_rd_data;
                    rsp_word_next.digit_char = rdc_digit_char(stack_rd_data);
                    rsp_word_next.last       = (depth_reg == '0);
                    rsp_word_next.bad_radix  = 1'b0;
                    state_next               = (depth_reg == '0) ? ST_IDLE : ST_POP_RD;
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_word_next.digit      = '0;
                    rsp_word_next.digit_char = '0;
                    rsp_word_next.last       = 1'b1;
                    rsp_word_next.bad_radix  = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg    <= radix_next;
        rsp_word_reg <= rsp_word_next;
    end

    rdc_divider #(
        .QW (QW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (radix_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    rdc_digit_stack u_stack (
        .clk     (clk),
        .req     (stack_req),
        .rd_data (stack_rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
`default_nettype wire

@@ rtl/core/rdc_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, divisor is the radix.
`default_nettype none
module rdc_divider
    import rdc_pkg::*;
#(
    parameter int QW = VALUE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [QW-1:0]          dividend,
    input  wire logic [RADIX_WIDTH-1:0] radix,
    output      logic [QW-1:0]          quotient,
    output      rdc_div_stat_t          stat
);

    localparam int CW = $clog2(QW);

    logic [QW-1:0]          q_reg, q_next;
    logic [DIGIT_WIDTH-1:0] rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [RADIX_WIDTH-1:0] partial;
    logic [RADIX_WIDTH-1:0] diff;
    logic                   ge;

    // remainder stays below the radix, so the shifted partial fits in the radix width
    assign partial = {rem_reg, q_reg[QW-1]};
    assign ge      = (partial >= radix);
    assign diff    = partial - radix;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CW'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[QW-2:0], ge};
            rem_next = ge ? diff[DIGIT_WIDTH-1:0] : partial[DIGIT_WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient       = q_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

endmodule
`default_nettype wire

@@ rtl/core/rdc_digit_stack.sv @@
// Digit stack storage: one write port, one registered read port.
`default_nettype none
module rdc_digit_stack
    import rdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire rdc_stack_req_t         req,
    output      logic [DIGIT_WIDTH-1:0] rd_data
);

    logic [DIGIT_WIDTH-1:0] mem [STACK_SLOTS];
    logic [DIGIT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/rdc_checker.sv @@
// Port-level checker for the radix digit converter, bound to the top level.
`default_nettype none
module rdc_checker
    import rdc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire rdc_in_t  req_word,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire rdc_out_t rsp_word
);

    // character always matches the digit on a normal word
    a_char_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.bad_radix |-> rsp_word.digit_char == rdc_digit_char(rsp_word.digit))
        else $error("digit_char does not match digit");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.bad_radix |->
            rsp_word.last && rsp_word.digit == '0 && rsp_word.digit_char == '0)
        else $error("malformed bad radix word");

    // block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after accept");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("output word dropped or changed while stalled");

endmodule

bind radix_digit_converter_top rdc_checker u_rdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
);
`default_nettype wire

@@ sim/radix_digit_converter_top_tb.sv @@
// Self-checking testbench for radix_digit_converter_top: digit prediction and ready/valid traffic.
`default_nettype none
module radix_digit_converter_top_tb;
    import rdc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 236;
    localparam int LONG_HOLD     = 4000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int MODE_SPAN     = 64;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO   = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] ASCII_LETTER = 7'h41;
    localparam logic [DIGIT_WIDTH-1:0] TEN         = 4'd10;

    // receiver stall patterns
    localparam int RX_OPEN  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;
    localparam int RX_MODES = 3;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    rdc_in_t  req_word  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    rdc_out_t rsp_word;

    rdc_in_t  pending_words[$];
    rdc_out_t expected_digits[$];

    int  words_queued  = 0;
    int  words_taken   = 0;
    int  errors        = 0;
    int  burst_left    = 0;
    int  gap_left      = 0;
    int  hold_left     = 0;
    int  mode_cycles   = 0;
    int  rx_mode       = RX_OPEN;
    logic hold_done    = 1'b0;
    logic random_phase = 1'b0;

    radix_digit_converter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Repeated division by the radix, then digits popped most significant first.
    task automatic predict_digits(input rdc_in_t w);
        logic [VALUE_WIDTH-1:0] quot;
        logic [DIGIT_WIDTH-1:0] rems[STACK_SLOTS];
        rdc_out_t               res;
        int                     count;
        int                     i;
        if (w.radix < MIN_RADIX || w.radix > MAX_RADIX)
        begin
            res.digit      = '0;
            res.digit_char = '0;
            res.last       = 1'b1;
            res.bad_radix  = 1'b1;
            expected_digits.push_back(res);
        end
        else
        begin
            quot  = w.value;
            count = 0;
            do
            begin
                rems[count] = DIGIT_WIDTH'(quot % w.radix);
                count++;
                quot = quot / w.radix;
            end
            while (quot != 0 && count < STACK_SLOTS);
            for (i = count - 1; i >= 0; i--)
            begin
                res.digit      = rems[i];
                res.digit_char = (rems[i] < TEN) ? ASCII_ZERO + CHAR_WIDTH'(rems[i])
                                                 : ASCII_LETTER + CHAR_WIDTH'(rems[i] - TEN);
                res.last       = (i == 0);
                res.bad_radix  = 1'b0;
                expected_digits.push_back(res);
            end
        end
    endtask

    task automatic queue_word(input logic [VALUE_WIDTH-1:0] v, input logic [RADIX_WIDTH-1:0] r);
        rdc_in_t w;
        w.value = v;
        w.radix = r;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // sender: bursts of words separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req_word   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                predict_digits(req_word);
                words_taken <= words_taken + 1;
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    req_valid <= 1'b1;
                    req_word  <= pending_words.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each digit word and stalls on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready   <= 1'b0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
            mode_cycles <= 0;
            rx_mode     <= RX_OPEN;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < MAX_REPORTS)
                        $display("unexpected word: digit=%0d char=%0d last=%0b bad=%0b",
                                 rsp_word.digit, rsp_word.digit_char, rsp_word.last,
                                 rsp_word.bad_radix);
                end
                else if (rsp_word.digit      !== expected_digits[0].digit      ||
                         rsp_word.digit_char !== expected_digits[0].digit_char ||
                         rsp_word.last       !== expected_digits[0].last       ||
                         rsp_word.bad_radix  !== expected_digits[0].bad_radix)
                begin
                    errors <= errors + 1;
                    if (errors < MAX_REPORTS)
                    begin
                        $display("mismatch: exp digit=%0d char=%0d last=%0b bad=%0b",
                                 expected_digits[0].digit, expected_digits[0].digit_char,
                                 expected_digits[0].last, expected_digits[0].bad_radix);
                        $display("          got digit=%0d char=%0d last=%0b bad=%0b",
                                 rsp_word.digit, rsp_word.digit_char, rsp_word.last,
                                 rsp_word.bad_radix);
                    end
                    void'(expected_digits.pop_front());
                end
                else
                begin
                    void'(expected_digits.pop_front());
                end
            end

            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (random_phase && !hold_done)
            begin
                // long hold-off so the output fills and the input backs up
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:  rsp_ready <= 1'b1;
                    RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
                    default:  rsp_ready <= ($urandom_range(0, 2) == 0);
                endcase
                if (mode_cycles >= MODE_SPAN)
                begin
                    mode_cycles <= 0;
                    rx_mode     <= $urandom_range(0, RX_MODES - 1);
                end
                else
                begin
                    mode_cycles <= mode_cycles + 1;
                end
            end
        end
    end

    initial
    begin
        int                     i;
        int                     sel;
        int                     pick;
        logic [VALUE_WIDTH-1:0] v;
        logic [RADIX_WIDTH-1:0] r;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero value, extremes, letter digits, bad radices
        queue_word(32'h0000_0000, 5'd2);
        queue_word(32'h0000_0000, 5'd10);
        queue_word(32'h0000_0000, 5'd16);
        queue_word(32'hFFFF_FFFF, 5'd2);
        queue_word(32'hFFFF_FFFF, 5'd3);
        queue_word(32'hFFFF_FFFF, 5'd10);
        queue_word(32'hFFFF_FFFF, 5'd16);
        queue_word(32'h0000_0001, 5'd2);
        queue_word(32'h0000_000F, 5'd16);
        queue_word(32'd10, 5'd11);
        queue_word(32'd12345, 5'd12);
        queue_word(32'd168, 5'd13);
        queue_word(32'hAAAA_AAAA, 5'd14);
        queue_word(32'h7FFF_FFFF, 5'd15);
        queue_word(32'h00AB_CDEF, 5'd16);
        queue_word(32'h8000_0000, 5'd2);
        queue_word(32'h8000_0000, 5'd7);
        queue_word(32'd12, 5'd12);
        queue_word(32'd255, 5'd4);
        queue_word(32'd5, 5'd0);
        queue_word(32'hFFFF_FFFF, 5'd1);
        queue_word(32'h0000_0000, 5'd17);
        queue_word(32'h5555_5555, 5'd31);
        queue_word(32'd99, 5'd9);

        // sender pause: everything drains before the random phase
        while (words_taken != words_queued || expected_digits.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                pick = $urandom_range(0, 16);
                r = (pick < 2) ? RADIX_WIDTH'(pick) : RADIX_WIDTH'(pick + 15);
            end
            else
            begin
                r = RADIX_WIDTH'($urandom_range(2, 16));
            end
            case ($urandom_range(0, 4))
                0:       v = $urandom;
                1:       v = $urandom_range(0, 255);
                2:       v = ($urandom_range(0, 1) == 0) ? '0 : '1;
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
            queue_word(v, r);
        end
        random_phase <= 1'b1;

        while (words_taken != words_queued || expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_digits.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
